// File: rtl/sha_pkg.sv
// SHA-256 stream hasher package: request codes, round constants, initial hash.
// No dependencies.
package sha_pkg;

	localparam logic [1:0] REQ_APPEND  = 2'd0;
	localparam logic [1:0] REQ_DIGEST  = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [60:0] TOTAL_LIMIT = {61{1'b1}};
	localparam logic [5:0]  PAD_LIMIT   = 6'd55;

	typedef logic [7:0][31:0] hash_t;

	localparam hash_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// Status from round unit back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} rnd_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/sha_req_if.sv
// Request channel interface: valid/ready with request type and message byte.
// Depends on nothing.
interface sha_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] msg_byte;
	modport source (output valid, req_type, msg_byte, input ready);
	modport sink (input valid, req_type, msg_byte, output ready);
endinterface

// File: rtl/sha_dig_if.sv
// Digest channel interface: valid/ready with one digest word and its tags.
// Depends on nothing.
interface sha_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        status;
	modport source (output valid, digest_word, word_index, last_word, status, input ready);
	modport sink (input valid, digest_word, word_index, last_word, status, output ready);
endinterface

// File: rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level: request intake, padding sequencer, output.
// Depends on sha_pkg, sha_req_if, sha_dig_if, sha_round.
//
// Usage: requests arrive on req (valid/ready). Append stores one byte; the
// 64th byte of a block starts a compression in the shared round unit, one
// round per cycle: req.ready comes back once the rounds are done and the
// result is folded into the chaining state. Other appends do not stall req.
// A digest request pads the buffered bytes and runs one or two compressions
// on a copy of the chaining state (two when more than 55 bytes are
// buffered), then sends eight words on dig, word 0 first, last_word on word
// 7, status carrying the sticky overflow flag. dig.valid rises once the
// last compression is done and its result is captured.
// req.ready is low while compressing and while digest words are pending; a
// stalled dig holds the current word.
// Restart reloads initial values. Reset (arst_n) gives the same state as
// restart. Appends beyond 2^61-1 bytes are dropped.
module sha256_stream_hasher_core
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_req_if.sink   req,
	sha_dig_if.source dig
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BLK  = 3'd1;
	localparam logic [2:0] ST_PAD1 = 3'd2;
	localparam logic [2:0] ST_PAD2 = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        st_q;
	hash_t             chain_q;
	hash_t             fin_q;
	logic [15:0][31:0] buf_q;
	logic [5:0]        nb_q;
	logic [60:0]       tot_q;
	logic              ovf_q;
	logic [2:0]        idx_q;

	logic              start;
	logic [15:0][31:0] blk;
	hash_t             h_in;
	hash_t             h_out;
	rnd_ctl_t          rc;
	logic [15:0][31:0] pad;
	logic [15:0][31:0] pad_len;
	logic [15:0][31:0] buf_next;
	logic              acc;

	assign acc = req.valid & req.ready;
	assign req.ready = (st_q == ST_IDLE) && !rc.busy;

	// Build padded block from buffer
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (6'(i * 4 + j) < nb_q) pad[i][31 - 8 * j -: 8] = buf_q[i][31 - 8 * j -: 8];
				else if (6'(i * 4 + j) == nb_q) pad[i][31 - 8 * j -: 8] = 8'h80;
				else pad[i][31 - 8 * j -: 8] = 8'h00;
			end
		end
		pad_len = (nb_q > PAD_LIMIT) ? '0 : pad;
		pad_len[14] = tot_q[60:29];
		pad_len[15] = {tot_q[28:0], 3'b000};
	end

	// Insert byte into the buffer
	always_comb begin
		buf_next = buf_q;
		buf_next[nb_q[5:2]][31 - 8 * nb_q[1:0] -: 8] = req.msg_byte;
	end

	// Pick round unit inputs
	always_comb begin
		start = 1'b0;
		blk   = buf_next;
		h_in  = chain_q;
		if (acc && req.req_type == REQ_APPEND && tot_q != TOTAL_LIMIT && nb_q == 6'd63)
			start = 1'b1;
		else if (acc && req.req_type == REQ_DIGEST) begin
			start = 1'b1;
			blk   = (nb_q > PAD_LIMIT) ? pad : pad_len;
		end else if (st_q == ST_PAD1 && rc.done) begin
			start = 1'b1;
			blk   = pad_len;
			h_in  = h_out;
		end
	end

	sha_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .blk(blk), .h_in(h_in),
		.h_out(h_out), .busy(rc.busy), .done(rc.done)
	);

	// Sequence requests, compressions and output words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			chain_q <= INIT_HASH;
			buf_q   <= '0;
			nb_q    <= '0;
			tot_q   <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.req_type)
							REQ_APPEND: begin
								if (tot_q == TOTAL_LIMIT) ovf_q <= 1'b1;
								else begin
									tot_q <= tot_q + 61'd1;
									nb_q  <= nb_q + 6'd1;
									if (nb_q == 6'd63) begin
										buf_q <= '0;
										st_q  <= ST_BLK;
									end else buf_q <= buf_next;
								end
							end
							REQ_DIGEST: st_q <= (nb_q > PAD_LIMIT) ? ST_PAD1 : ST_PAD2;
							REQ_RESTART: begin
								chain_q <= INIT_HASH;
								buf_q   <= '0;
								nb_q    <= '0;
								tot_q   <= '0;
								ovf_q   <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_BLK: if (rc.done) begin
					chain_q <= h_out;
					st_q    <= ST_IDLE;
				end
				ST_PAD1: if (rc.done) st_q <= ST_PAD2;
				ST_PAD2: if (rc.done) begin
					idx_q <= '0;
					st_q  <= ST_OUT;
				end
				ST_OUT: if (dig.ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the finished digest
	always_ff @(posedge clk) begin
		if (st_q == ST_PAD2 && rc.done) fin_q <= h_out;
	end

	assign dig.valid       = (st_q == ST_OUT);
	assign dig.digest_word = fin_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == 3'd7);
	assign dig.status      = ovf_q;

`ifndef ASSERT_OFF
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rc.busy |-> !req.ready) else $error("request taken during compression");
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid && dig.ready && !dig.last_word |=> dig.valid
		&& dig.word_index == $past(dig.word_index) + 3'd1) else $error("word order");
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ovf_q) |-> $past(acc && req.req_type == REQ_RESTART))
		else $error("overflow flag cleared");
`endif

endmodule

// File: rtl/sha_round.sv
// Shared SHA-256 round unit: one round per cycle with a rolling schedule window.
// Depends on sha_pkg.
module sha_round
	import sha_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [15:0][31:0] blk,
	input  hash_t            h_in,
	output hash_t            h_out,
	output logic             busy,
	output logic             done
);

	logic [15:0][31:0] w_q;
	hash_t             v_q;
	hash_t             h_q;
	logic [5:0]        t_q;
	logic              busy_q;
	logic              done_q;

	logic [31:0] a15, a2, s0, s1, wnew, wt, t1, t2, e, a;

	// Window always holds w[t..t+15] at w_q[0]; compute w[t+16] ahead
	always_comb begin
		a15  = w_q[1];
		a2   = w_q[14];
		s0   = {a15[6:0], a15[31:7]} ^ {a15[17:0], a15[31:18]} ^ (a15 >> 3);
		s1   = {a2[16:0], a2[31:17]} ^ {a2[18:0], a2[31:19]} ^ (a2 >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		wt   = w_q[0];
		e    = v_q[4];
		a    = v_q[0];
		t1   = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
		     + ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(t_q) + wt;
		t2   = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
		     + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Advance round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			t_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				t_q    <= '0;
			end else if (busy_q) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold working variables and schedule
	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= blk;
			v_q <= h_in;
			h_q <= h_in;
		end else if (busy_q) begin
			w_q <= {wnew, w_q[15:1]};
			v_q[0] <= t1 + t2;
			v_q[4] <= v_q[3] + t1;
			v_q[1] <= v_q[0]; v_q[2] <= v_q[1]; v_q[3] <= v_q[2];
			v_q[5] <= v_q[4]; v_q[6] <= v_q[5]; v_q[7] <= v_q[6];
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) h_out[i] = h_q[i] + v_q[i];
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: test/testbench.sv
// Self-checking testbench for sha256_stream_hasher_core: random byte streams,
// digests and restarts checked word by word against a behavioral SHA-256 predictor.
// Depends on sha_pkg, sha_req_if, sha_dig_if and the hasher RTL.
module testbench;
	import sha_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 500;
	localparam int DRAIN_WAIT  = 150;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
		logic        status;
	} dig_word_t;

	// Digest predictor: own copy of chaining state, block bytes and length.
	class digest_scoreboard;
		logic [31:0] chain[8];
		logic [7:0]  blk[64];
		int unsigned fill;
		logic [60:0] total;
		logic        ovf;
		dig_word_t   expected_words[$];
		bit          failed;

		function new();
			restart();
			failed = 0;
		endfunction

		function void restart();
			chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			foreach (blk[i]) blk[i] = 8'h00;
			fill = 0;
			total = '0;
			ovf = 0;
		endfunction

		static function logic [31:0] rotr(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		static function logic [31:0] kconst(int t);
			logic [31:0] k[64];
			k = '{
				32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
				32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
				32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
				32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
				32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
				32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
				32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
				32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
				32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
				32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
				32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
			return k[t];
		endfunction

		// Fold one 64-byte block into h.
		static function void compress(input logic [7:0] b[64], inout logic [31:0] h[8]);
			logic [31:0] w[64];
			logic [31:0] v[8];
			logic [31:0] s0, s1, t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
			for (int t = 16; t < 64; t++) begin
				s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
				s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
				w[t] = w[t-16] + s0 + w[t-7] + s1;
			end
			v = h;
			for (int t = 0; t < 64; t++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w[t];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) h[i] += v[i];
		endfunction

		// Note one accepted request and queue the words it produces.
		function void note_request(logic [1:0] kind, logic [7:0] data);
			logic [7:0]  pad[64];
			logic [31:0] fin[8];
			logic [63:0] bits;
			dig_word_t   e;
			case (kind)
				REQ_APPEND: begin
					if (total == TOTAL_LIMIT) begin
						ovf = 1;
					end else begin
						blk[fill] = data;
						fill++;
						total++;
						if (fill == 64) begin
							compress(blk, chain);
							foreach (blk[i]) blk[i] = 8'h00;
							fill = 0;
						end
					end
				end
				REQ_RESTART: restart();
				REQ_DIGEST: begin
					fin = chain;
					foreach (pad[i]) pad[i] = (i < fill) ? blk[i] : 8'h00;
					pad[fill] = 8'h80;
					if (fill > PAD_LIMIT) begin
						compress(pad, fin);
						foreach (pad[i]) pad[i] = 8'h00;
					end
					bits = {total, 3'b000};
					for (int i = 0; i < 8; i++) pad[56+i] = bits[63-8*i -: 8];
					compress(pad, fin);
					for (int i = 0; i < 8; i++) begin
						e.word = fin[i];
						e.index = i[2:0];
						e.last = (i == 7);
						e.status = ovf;
						expected_words.push_back(e);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_word(logic [31:0] word, logic [2:0] index, logic last, logic status);
			dig_word_t e;
			if (expected_words.size() == 0) begin
				$error("digest word %h with nothing expected", word);
				failed = 1;
				return;
			end
			e = expected_words.pop_front();
			if (word !== e.word) begin
				$error("digest_word expected %h actual %h", e.word, word);
				failed = 1;
			end
			if (index !== e.index) begin
				$error("word_index expected %0d actual %0d", e.index, index);
				failed = 1;
			end
			if (last !== e.last) begin
				$error("last_word expected %0d actual %0d", e.last, last);
				failed = 1;
			end
			if (status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, status);
				failed = 1;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	sha_req_if req();
	sha_dig_if dig();
	digest_scoreboard sb = new();
	int idle_cycles = 0;
	int accepted_requests = 0;
	bit hold_armed = 0;

	sha256_stream_hasher_core u_top (.clk(clk), .arst_n(arst_n), .req(req), .dig(dig));

	always #HALF_PERIOD clk = ~clk;

	// Observe handshakes on both channels and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				sb.note_request(req.req_type, req.msg_byte);
				accepted_requests++;
			end
			if (dig.valid && dig.ready)
				sb.check_word(dig.digest_word, dig.word_index, dig.last_word, dig.status);
			if ((req.valid && req.ready) || (dig.valid && dig.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Drive digest ready: random stretches, plus one long hold-off.
	initial begin
		int run_left;
		bit hold_done;
		run_left = 0;
		hold_done = 0;
		dig.ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done && dig.valid) begin
				hold_done = 1;
				dig.ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				run_left = 0;
			end
			if (run_left == 0) begin
				run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 6);
				dig.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				run_left--;
			end
		end
	end

	task automatic send(logic [1:0] kind, logic [7:0] data);
		req.valid <= 1;
		req.req_type <= kind;
		req.msg_byte <= data;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 2) != 0) ? 0
			: (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4));
		if (n > 0) begin
			req.valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic append_bytes(int count);
		for (int i = 0; i < count; i++) begin
			send(REQ_APPEND, 8'($urandom_range(0, 255)));
			gap();
		end
	endtask

	task automatic wait_drained();
		req.valid <= 0;
		@(posedge clk);
		while (sb.expected_words.size() != 0) @(posedge clk);
	endtask

	initial begin
		int msg_len;
		req.valid <= 0;
		req.req_type <= REQ_APPEND;
		req.msg_byte <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty digest, byte extremes, unused code, restart.
		send(REQ_DIGEST, 8'h00);
		send(REQ_APPEND, 8'h00);
		send(REQ_APPEND, 8'hff);
		send(REQ_DIGEST, 8'hff);
		send(REQ_UNUSED, 8'ha5);
		send(REQ_DIGEST, 8'h5a);
		send(REQ_RESTART, 8'hff);
		send(REQ_DIGEST, 8'h00);
		send(REQ_APPEND, 8'h80);
		send(REQ_APPEND, 8'h7f);
		send(REQ_RESTART, 8'h00);
		send(REQ_DIGEST, 8'h00);

		// Sender pause: let every digest word come out.
		wait_drained();

		// Random messages, lengths biased toward the padding boundaries.
		while (accepted_requests < 310) begin
			if (accepted_requests > 120) hold_armed = 1;
			case ($urandom_range(0, 5))
				0: msg_len = 55;
				1: msg_len = 56;
				2: msg_len = $urandom_range(60, 70);
				3: msg_len = $urandom_range(120, 130);
				default: msg_len = $urandom_range(0, 20);
			endcase
			if (msg_len > 40 && $urandom_range(0, 1)) begin
				append_bytes(msg_len / 2);
				send(REQ_DIGEST, 8'($urandom_range(0, 255)));
				gap();
				append_bytes(msg_len - msg_len / 2);
			end else begin
				append_bytes(msg_len);
			end
			if ($urandom_range(0, 7) == 0) begin
				send(REQ_UNUSED, 8'($urandom_range(0, 255)));
				gap();
			end
			send(REQ_DIGEST, 8'($urandom_range(0, 255)));
			gap();
			if ($urandom_range(0, 2) != 0) begin
				send(REQ_RESTART, 8'($urandom_range(0, 255)));
				gap();
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (!sb.failed && sb.expected_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
